// File: hw/rtl/msld_pkg.sv
// Package: types and constants shared by the length-prefixed frame deframer.
`timescale 1ns / 1ps
package msld_pkg;

	// Hunting window depth and header layout
	localparam int unsigned HdrBytes = 12;
	localparam int unsigned IdxW     = 4;
	localparam int unsigned LenW     = 32;
	localparam int unsigned RemW     = 17;

	// Largest frame the downstream buffer holds
	localparam int unsigned BufferBytes = 65536;

	// Sync word "VM3 " in window bytes 8 to 11
	localparam logic [7:0] Magic0 = 8'h56;
	localparam logic [7:0] Magic1 = 8'h4d;
	localparam logic [7:0] Magic2 = 8'h33;
	localparam logic [7:0] Magic3 = 8'h20;

	localparam logic [RemW-1:0] MaxFrameReset = 17'h10000;
	localparam logic [31:0]     CounterReset  = 32'd1;

	// Register map, one 32-bit word per register
	typedef enum logic [1:0] {
		RegCrate     = 2'd0,
		RegControl   = 2'd1,
		RegProcessor = 2'd2,
		RegMaxFrame  = 2'd3
	} cfg_reg_t;

	// One result item
	typedef struct packed {
		logic [7:0]  byte_val;
		logic        first;
		logic        last;
		logic [31:0] number;
		logic [7:0]  crate;
		logic [7:0]  control;
		logic [15:0] processor;
	} out_item_t;

endpackage

// File: hw/rtl/magic_sync_length_deframer.sv
// Top level: sync-word hunting deframer for length-prefixed frames in a byte stream.
`timescale 1ns / 1ps
// Frame bytes pass through the input register and then the output register; the 12
// window bytes of a matched header load into the output register after its last byte.
// Throughput: 1 byte per cycle while hunting, and inside a frame while frame_ready holds;
// a header burst holds the input while the single output register drains the window.
// Reset: tags clear to 0, limit to 65536, frame counter to 1; hunt with an empty window.
module magic_sync_length_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// raw byte stream
	input  logic        stream_valid,
	output logic        stream_ready,
	input  logic [7:0]  stream_byte,
	// frame bytes
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_first,
	output logic        frame_last,
	output logic [31:0] frame_number,
	output logic [7:0]  crate_tag,
	output logic [7:0]  control_tag,
	output logic [15:0] processor_tag,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import msld_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [7:0]      crate_q;
	logic [7:0]      control_q;
	logic [15:0]     processor_q;
	logic [RemW-1:0] max_frame_q;
	logic            cfg_wr;
	cfg_reg_t        cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crate_q     <= '0;
			control_q   <= '0;
			processor_q <= '0;
			max_frame_q <= MaxFrameReset;
		end else if (cfg_wr) begin
			case (cfg_sel)
				RegCrate:     crate_q     <= pwdata[7:0];
				RegControl:   control_q   <= pwdata[7:0];
				RegProcessor: processor_q <= pwdata[15:0];
				RegMaxFrame:  max_frame_q <= pwdata[RemW-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			RegCrate:     prdata = {24'd0, crate_q};
			RegControl:   prdata = {24'd0, control_q};
			RegProcessor: prdata = {16'd0, processor_q};
			RegMaxFrame:  prdata = {{(32-RemW){1'b0}}, max_frame_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       proc_go;

	// Take a new byte whenever the stage is empty or its byte moves on this cycle
	assign stream_ready = !valid_s1 || proc_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_valid && stream_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && stream_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	// ---------------------------------------------------------------
	// Deframer state
	// ---------------------------------------------------------------
	logic [7:0]      win_q [HdrBytes];
	logic [IdxW-1:0] fill_q;      // bytes held while hunting, 0 to 11
	logic            in_frame_q;
	logic [RemW-1:0] rem_q;       // payload bytes still to pass after the header
	logic [31:0]     counter_q;
	logic            burst_q;     // header bytes are being drained
	logic [IdxW-1:0] burst_idx_q;
	logic            done_q;      // the frame is just its 12-byte header

	logic            out_valid_q;
	out_item_t       out_q;
	logic            out_free;
	logic            burst_go;
	logic            burst_end;
	logic            out_load;
	out_item_t       out_d;

	// Window after writing the new byte at the fill position
	logic [7:0]      nw [HdrBytes];
	logic            full;
	logic            magic_ok;
	logic [LenW-1:0] len;
	logic [LenW:0]   total;
	logic [RemW-1:0] limit;
	logic            hit;
	logic            frame_end;

	always_comb begin
		for (int i = 0; i < HdrBytes; i++) begin
			nw[i] = (fill_q == IdxW'(i)) ? byte_s1 : win_q[i];
		end
	end

	// Header check: sync word in place and total length L+4 within [12, limit]
	assign full     = (fill_q == IdxW'(HdrBytes - 1));
	assign magic_ok = (nw[8] == Magic0) && (nw[9] == Magic1) &&
	                  (nw[10] == Magic2) && (nw[11] == Magic3);
	assign len      = {nw[0], nw[1], nw[2], nw[3]};
	assign total    = {1'b0, len} + (LenW+1)'(4);
	assign limit    = (max_frame_q > RemW'(BufferBytes)) ? RemW'(BufferBytes) : max_frame_q;
	assign hit      = full && magic_ok && (total >= (LenW+1)'(HdrBytes)) &&
	                  (total <= {{(LenW+1-RemW){1'b0}}, limit});

	// Output register can take an item this cycle
	assign out_free = !out_valid_q || frame_ready;

	// Advance the input stage: hunting bytes never need the output, frame bytes do,
	// and nothing moves while the header drains
	assign proc_go   = valid_s1 && !burst_q && (!in_frame_q || out_free);
	assign burst_go  = burst_q && out_free;
	assign burst_end = burst_go && (burst_idx_q == IdxW'(HdrBytes - 1));
	assign frame_end = proc_go && in_frame_q && (rem_q <= RemW'(1));
	assign out_load  = burst_go || (proc_go && in_frame_q);

	always_comb begin
		out_d.crate     = crate_q;
		out_d.control   = control_q;
		out_d.processor = processor_q;
		out_d.number    = counter_q;
		if (burst_q) begin
			out_d.byte_val = win_q[burst_idx_q];
			out_d.first    = (burst_idx_q == '0);
			out_d.last     = done_q && (burst_idx_q == IdxW'(HdrBytes - 1));
		end else begin
			out_d.byte_val = byte_s1;
			out_d.first    = 1'b0;
			out_d.last     = (rem_q <= RemW'(1));
		end
	end

	// Window: write the new byte while hunting, drop the oldest on a mismatch
	always_ff @(posedge clk) begin
		if (proc_go && !in_frame_q) begin
			for (int i = 0; i < HdrBytes; i++) begin
				if (full && !hit) begin
					win_q[i] <= (i < HdrBytes - 1) ? nw[(i + 1) % HdrBytes] : nw[i];
				end else begin
					win_q[i] <= nw[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			in_frame_q  <= 1'b0;
			rem_q       <= '0;
			counter_q   <= CounterReset;
			burst_q     <= 1'b0;
			burst_idx_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (proc_go) begin
				if (in_frame_q) begin
					// pass a payload byte; close the frame on its last byte
					if (frame_end) begin
						in_frame_q <= 1'b0;
						fill_q     <= '0;
						counter_q  <= counter_q + 32'd1;
					end else begin
						rem_q <= rem_q - RemW'(1);
					end
				end else if (hit) begin
					// header found: drain the window, then pass the payload
					fill_q      <= '0;
					burst_q     <= 1'b1;
					burst_idx_q <= '0;
					done_q      <= (total == (LenW+1)'(HdrBytes));
					in_frame_q  <= (total != (LenW+1)'(HdrBytes));
					rem_q       <= RemW'(total - (LenW+1)'(HdrBytes));
				end else if (!full) begin
					fill_q <= fill_q + IdxW'(1);
				end
			end
			if (burst_go) begin
				burst_idx_q <= burst_idx_q + IdxW'(1);
				if (burst_end) begin
					burst_q <= 1'b0;
					if (done_q) begin
						counter_q <= counter_q + 32'd1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (frame_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign frame_valid   = out_valid_q;
	assign frame_byte    = out_q.byte_val;
	assign frame_first   = out_q.first;
	assign frame_last    = out_q.last;
	assign frame_number  = out_q.number;
	assign crate_tag     = out_q.crate;
	assign control_tag   = out_q.control;
	assign processor_tag = out_q.processor;

endmodule
